// ===== rtl/backslash_escape_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Backslash escape decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication
`define BED_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BED_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Character codes, decode modes, queue entry layout and decode helpers.
// ----------------------------------------------------------------------------
package bed_pkg;

	localparam logic [7:0] CHR_NUL = 8'h00;
	localparam logic [7:0] CHR_BSL = 8'h5C;
	localparam logic [7:0] CHR_X   = 8'h78;
	localparam logic [7:0] CHR_N   = 8'h6E;
	localparam logic [7:0] CHR_R   = 8'h72;
	localparam logic [7:0] CHR_A   = 8'h61;
	localparam logic [7:0] CHR_T   = 8'h74;
	localparam logic [7:0] CHR_B   = 8'h62;
	localparam logic [7:0] CHR_F   = 8'h66;
	localparam logic [7:0] CHR_V   = 8'h76;

	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_BEL = 8'h07;
	localparam logic [7:0] CTL_HT  = 8'h09;
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_VT  = 8'h0B;

	localparam logic [15:0] MAX_OUT_RST = 16'hFFFF;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_HEX0   = 4'b0100,
		MODE_HEX1   = 4'b1000
	} mode_t;

	// up to two operations per input byte: an optional leading byte, then
	// an optional byte or end record
	typedef struct packed {
		logic       first_vld;
		logic [7:0] first_byte;
		logic       second_vld;
		logic       second_end;
		logic [7:0] second_byte;
	} entry_t;

	typedef struct packed {
		logic       push;
		entry_t     ent;
	} push_t;

	typedef struct packed {
		logic       vld;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t       h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d = b - 8'h30;
			h.vld = 1'b1;
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d = b - 8'h57;
			h.vld = 1'b1;
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d = b - 8'h37;
			h.vld = 1'b1;
		end
		h.val = d[3:0];
		return h;
	endfunction

	function automatic logic [7:0] escape_code(input logic [7:0] b);
		logic [7:0] c;
		unique case (b)
			CHR_N:   c = CTL_LF;
			CHR_R:   c = CTL_CR;
			CHR_A:   c = CTL_BEL;
			CHR_T:   c = CTL_HT;
			CHR_B:   c = CTL_BS;
			CHR_F:   c = CTL_FF;
			CHR_V:   c = CTL_VT;
			default: c = b;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/bed_front.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder front end
// Accepts input bytes, tracks the escape mode and pushes decode operations.
// ----------------------------------------------------------------------------
module bed_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               q_full,
	output bed_pkg::push_t     q_push
);

	bed_pkg::mode_t  mode_q, mode_d;
	logic [3:0]      nib_q, nib_d;
	bed_pkg::hex_t   hex;
	bed_pkg::entry_t ent;
	bed_pkg::mode_t  pl_mode;
	logic            pl_vld;
	logic            pl_end;
	logic            acc;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign hex      = bed_pkg::hex_decode(in_byte);

	// byte handled as ordinary text
	always_comb begin
		pl_mode = bed_pkg::MODE_NORMAL;
		pl_vld  = 1'b1;
		pl_end  = 1'b0;
		if (in_byte == bed_pkg::CHR_NUL) begin
			pl_end = 1'b1;
		end else if (in_byte == bed_pkg::CHR_BSL) begin
			pl_mode = bed_pkg::MODE_ESCAPE;
			pl_vld  = 1'b0;
		end
	end

	always_comb begin
		ent    = '0;
		mode_d = mode_q;
		nib_d  = nib_q;
		unique case (mode_q)
			bed_pkg::MODE_NORMAL: begin
				mode_d          = pl_mode;
				ent.second_vld  = pl_vld;
				ent.second_end  = pl_end;
				ent.second_byte = in_byte;
			end
			bed_pkg::MODE_ESCAPE: begin
				if (in_byte == bed_pkg::CHR_NUL) begin
					mode_d         = bed_pkg::MODE_NORMAL;
					ent.second_vld = 1'b1;
					ent.second_end = 1'b1;
				end else if (in_byte == bed_pkg::CHR_X) begin
					mode_d = bed_pkg::MODE_HEX0;
				end else begin
					mode_d          = bed_pkg::MODE_NORMAL;
					ent.second_vld  = 1'b1;
					ent.second_byte = bed_pkg::escape_code(in_byte);
				end
			end
			bed_pkg::MODE_HEX0: begin
				if (hex.vld) begin
					nib_d  = hex.val;
					mode_d = bed_pkg::MODE_HEX1;
				end else begin
					ent.first_vld   = 1'b1;
					ent.first_byte  = bed_pkg::CHR_X;
					mode_d          = pl_mode;
					ent.second_vld  = pl_vld;
					ent.second_end  = pl_end;
					ent.second_byte = in_byte;
				end
			end
			bed_pkg::MODE_HEX1: begin
				nib_d = '0;
				if (hex.vld) begin
					mode_d          = bed_pkg::MODE_NORMAL;
					ent.second_vld  = 1'b1;
					ent.second_byte = {nib_q, hex.val};
				end else begin
					ent.first_vld   = 1'b1;
					ent.first_byte  = {4'h0, nib_q};
					mode_d          = pl_mode;
					ent.second_vld  = pl_vld;
					ent.second_end  = pl_end;
					ent.second_byte = in_byte;
				end
			end
			default: begin
				mode_d = bed_pkg::MODE_NORMAL;
				nib_d  = '0;
			end
		endcase
		if (ent.second_end) begin
			ent.second_byte = '0;
		end
	end

	assign q_push.push = acc && (ent.first_vld || ent.second_vld);
	assign q_push.ent  = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bed_pkg::MODE_NORMAL;
			nib_q  <= '0;
		end else if (acc) begin
			mode_q <= mode_d;
			nib_q  <= nib_d;
		end
	end

endmodule

// ===== rtl/bed_fifo.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder operation queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bed_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  bed_pkg::push_t     q_push,
	output logic               q_full,
	input  logic               pop,
	output logic               head_vld,
	output bed_pkg::entry_t    head
);

	bed_pkg::entry_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign q_full   = (cnt_q == 2'd2);
	assign head_vld = (cnt_q != 2'd0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push.push) begin
			mem_q[wr_ptr_q] <= q_push.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (q_push.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({q_push.push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/bed_back.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder back end
// Applies the output limit, counts bytes and drives the output register.
// ----------------------------------------------------------------------------
module bed_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [15:0]        cfg_data,
	input  logic               head_vld,
	input  bed_pkg::entry_t    head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_end,
	output logic [7:0]         out_byte,
	output logic [15:0]        byte_count
);

	`include "backslash_escape_decoder_macros.svh"

	logic [15:0] max_q;
	logic [15:0] cnt_q;
	logic        phase_q;
	logic        out_vld_q;
	logic        out_end_q;
	logic [7:0]  out_byte_q;
	logic [15:0] out_cnt_q;

	logic        use_first;
	logic        op_end;
	logic [7:0]  op_byte;
	logic        op_last;
	logic        out_free;
	logic        drop;
	logic        op_go;
	logic [15:0] cnt_inc;

	assign use_first = head.first_vld && !phase_q;
	assign op_end    = use_first ? 1'b0 : head.second_end;
	assign op_byte   = use_first ? head.first_byte : head.second_byte;
	assign op_last   = !(use_first && head.second_vld);
	assign out_free  = !out_vld_q || !out_stall;
	assign drop      = !op_end && (cnt_q >= max_q);
	assign op_go     = head_vld && (drop || out_free);
	assign pop       = op_go && op_last;
	assign cnt_inc   = cnt_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= bed_pkg::MAX_OUT_RST;
		end else if (cfg_valid) begin
			max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			phase_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (op_go) begin
				phase_q <= !op_last;
				if (op_end) begin
					cnt_q <= '0;
				end else if (!drop) begin
					cnt_q <= cnt_inc;
				end
			end
			if (out_free) begin
				out_vld_q <= op_go && !drop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && op_go && !drop) begin
			out_end_q  <= op_end;
			out_byte_q <= op_end ? 8'h00 : op_byte;
			out_cnt_q  <= op_end ? cnt_q : cnt_inc;
		end
	end

	assign out_valid  = out_vld_q;
	assign is_end     = out_end_q;
	assign out_byte   = out_byte_q;
	assign byte_count = out_cnt_q;

	`BED_ASSERT_IMP(a_byte_cnt_nz, out_vld_q && !out_end_q, out_cnt_q != 16'd0,
		"decoded byte beat with zero count")
	`BED_ASSERT_IMP(a_end_byte_zero, out_vld_q && out_end_q, out_byte_q == 8'h00,
		"end record with nonzero byte")
	`BED_ASSERT_IMP(a_phase_head, phase_q, head_vld,
		"second operation pending with empty queue")
	`BED_ASSERT_NXT(a_end_clears_cnt, op_go && op_end, cnt_q == 16'd0,
		"count not cleared after end record")

endmodule

// ===== rtl/backslash_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Decodes C-style backslash escapes in a byte stream, one string per NUL.
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle while in_stall is low; escape state is
// kept in the front end, and each byte that yields output pushes one entry
// into a two-entry queue. The back end drains one operation per cycle into
// the output register while out_stall is low, and a byte that yields two
// results (a flushed "\x" or single hex digit followed by another byte or
// the end record) holds the back end until both operations are done. Each
// decoded byte beat carries its running count; the NUL byte produces an end
// record with the string total. Bytes past the configured limit are dropped
// without a beat. The configuration register is always ready and takes
// effect on the operations that the back end handles after the write.
module backslash_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_end,
	output logic [7:0]  out_byte,
	output logic [15:0] byte_count
);

	bed_pkg::push_t  q_push;
	bed_pkg::entry_t head;
	logic            q_full;
	logic            head_vld;
	logic            pop;
	logic            cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	bed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push)
	);

	bed_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.q_full   (q_full),
		.pop      (pop),
		.head_vld (head_vld),
		.head     (head)
	);

	bed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_wr),
		.cfg_data   (cfg_data),
		.head_vld   (head_vld),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_end     (is_end),
		.out_byte   (out_byte),
		.byte_count (byte_count)
	);

endmodule
